/* sv/chte_pkg.sv */
// chte_pkg: shared types and constants of the chained hash table engine.
// No dependencies.
package chte_pkg;

    localparam logic [31:0] HASH_MUL = 32'h045d9f3b;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_SAME     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4,
        ST_NO_SPACE = 3'd5
    } status_t;

endpackage

/* sv/chte_ram.sv */
// chte_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/chte_hash.sv */
// chte_hash: two-stage pipelined key hash giving the bucket index.
// Depends on chte_pkg.
module chte_hash #(
    parameter int BUCKETS = 256
) (
    input  logic                       clk,
    input  logic [31:0]                key,
    output logic [$clog2(BUCKETS)-1:0] bucket
);
    logic [31:0] h1_reg;
    logic [31:0] h2;
    logic [31:0] h3_reg;
    logic [31:0] h4;
    logic [31:0] bucket_full;

    always_comb
    begin
        h2 = (h1_reg >> 16) ^ h1_reg;
        h4 = (h3_reg >> 16) ^ h3_reg;
        bucket_full = h4 % BUCKETS;
    end

    always_ff @(posedge clk)
    begin
        h1_reg <= ((key >> 16) ^ key) * chte_pkg::HASH_MUL;
        h3_reg <= h2 * chte_pkg::HASH_MUL;
    end

    assign bucket = bucket_full[$clog2(BUCKETS)-1:0];
endmodule

/* sv/chained_hash_table_engine.sv */
// chained_hash_table_engine: key/value table with separate chaining in RAM.
// Depends on chte_pkg, chte_ram, chte_hash.
//
// channel | direction | handshake            | payload
// request | in        | in_valid / in_ready  | cmd, key, value
// result  | out       | out_valid / out_ready| status, value_out, entries_held
//
// Steps: S_HASH and S_HASH2 hash the key, S_HEAD fetches the head entry,
// S_READ and S_CHECK test it and repeat for each further entry, S_POP,
// S_LINK and S_TAIL link a new key, and S_DONE loads the result and
// returns to idle. Reset sweeps the heads in S_CLEAR to clear them; a
// low-water mark on the free stack stands in for slots never written.
// A request is taken while a result waits; the next result holds in S_DONE.
module chained_hash_table_engine #(
    parameter int BUCKETS    = 256,
    parameter int ENTRIES    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] value_out,
    output logic [10:0] entries_held
);
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int LW = EW + 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);
    localparam logic [LW-1:0] FULL = LW'(ENTRIES);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_HASH   = 13'b0000000000100,
        S_HEAD   = 13'b0000000001000,
        S_HEADW  = 13'b0000000010000,
        S_READ   = 13'b0000000100000,
        S_CHECK  = 13'b0000001000000,
        S_TAIL   = 13'b0000010000000,
        S_TAILC  = 13'b0000100000000,
        S_POP    = 13'b0001000000000,
        S_LINK   = 13'b0010000000000,
        S_DONE   = 13'b0100000000000,
        S_HASH2  = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [BW-1:0]     clr_reg, clr_next;
    chte_pkg::cmd_t    cmd_reg, cmd_next;
    logic [31:0]       key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [BW-1:0]     bkt_reg, bkt_next;
    logic [LW-1:0]     cur_reg, cur_next;
    logic [LW-1:0]     prev_reg, prev_next;
    logic [LW-1:0]     free_top_reg, free_top_next;
    logic [LW-1:0]     count_reg, count_next;
    logic [LW-1:0]     slot_reg, slot_next;
    logic [LW-1:0]     steps_reg, steps_next;
    logic              ov_reg, ov_next;
    logic [2:0]        st_reg, st_next;
    logic [31:0]       vo_reg, vo_next;
    logic [2:0]        out_st_reg, out_st_next;
    logic [31:0]       out_vo_reg, out_vo_next;
    logic [10:0]       out_held_reg, out_held_next;

    logic [BW-1:0]     bucket;
    logic              hd_we;
    logic [BW-1:0]     hd_waddr, hd_raddr;
    logic [LW-1:0]     hd_wdata, hd_rdata;
    logic              e_we, k_we, l_we, f_we;
    logic [EW-1:0]     e_waddr, e_raddr, l_waddr, f_waddr, f_raddr;
    logic [31:0]       k_rdata;
    logic [VALUE_BITS-1:0] v_wdata, v_rdata;
    logic [LW-1:0]     l_wdata, l_rdata;
    logic [EW-1:0]     f_wdata, f_rdata;
    logic [LW-1:0]     free_low_reg, free_low_next;
    logic [EW-1:0]     f_raddr_reg;

    chte_hash #(.BUCKETS(BUCKETS)) u_hash (.clk(clk), .key(key_next), .bucket(bucket));

    chte_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata));
    chte_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (
        .clk(clk), .we(k_we), .waddr(e_waddr), .wdata(key_reg),
        .raddr(e_raddr), .rdata(k_rdata));
    chte_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(v_wdata),
        .raddr(e_raddr), .rdata(v_rdata));
    chte_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(e_raddr), .rdata(l_rdata));
    chte_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_free (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));

    logic [EW-1:0] free_slot;
    assign free_slot = (LW'(f_raddr_reg) < free_low_reg) ? f_raddr_reg : f_rdata;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign status = out_st_reg;
    assign value_out = out_vo_reg;
    assign entries_held = out_held_reg;
    assign hd_raddr = bkt_next;
    assign e_raddr = cur_next[EW-1:0];
    assign f_raddr = EW'(free_top_reg - LW'(1));

    always_ff @(posedge clk)
    begin
        f_raddr_reg <= f_raddr;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        cmd_next = cmd_reg;
        key_next = key_reg;
        val_next = val_reg;
        bkt_next = bkt_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        free_top_next = free_top_reg;
        count_next = count_reg;
        slot_next = slot_reg;
        steps_next = steps_reg;
        ov_next = ov_reg;
        st_next = st_reg;
        vo_next = vo_reg;
        out_st_next = out_st_reg;
        out_vo_next = out_vo_reg;
        out_held_next = out_held_reg;
        free_low_next = free_low_reg;
        hd_we = 1'b0;
        hd_waddr = bkt_reg;
        hd_wdata = NULL_LINK;
        e_we = 1'b0;
        k_we = 1'b0;
        e_waddr = cur_reg[EW-1:0];
        v_wdata = val_reg;
        l_we = 1'b0;
        l_waddr = cur_reg[EW-1:0];
        l_wdata = NULL_LINK;
        f_we = 1'b0;
        f_waddr = EW'(free_top_reg);
        f_wdata = cur_reg[EW-1:0];
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                hd_we = 1'b1;
                hd_waddr = clr_reg;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = chte_pkg::cmd_t'(cmd);
                    key_next = key;
                    val_next = VALUE_BITS'(value);
                    state_next = S_HASH;
                end
            end
            S_HASH: state_next = S_HASH2;
            S_HASH2:
            begin
                bkt_next = bucket;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                cur_next = hd_rdata;
                prev_next = NULL_LINK;
                steps_next = '0;
                state_next = S_READ;
            end
            S_READ: state_next = S_CHECK;
            S_CHECK:
            begin
                if (cur_reg == NULL_LINK || steps_reg == FULL)
                begin
                    if (cmd_reg == chte_pkg::CMD_INSERT)
                    begin
                        if (free_top_reg == '0)
                        begin
                            st_next = chte_pkg::ST_NO_SPACE;
                            vo_next = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next = prev_reg;
                            state_next = S_POP;
                        end
                    end
                    else
                    begin
                        st_next = chte_pkg::ST_MISSING;
                        vo_next = '0;
                        state_next = S_DONE;
                    end
                end
                else if (k_rdata == key_reg)
                begin
                    case (cmd_reg)
                        chte_pkg::CMD_INSERT:
                        begin
                            vo_next = '0;
                            if (v_rdata == val_reg)
                            begin
                                st_next = chte_pkg::ST_SAME;
                            end
                            else
                            begin
                                e_we = 1'b1;
                                st_next = chte_pkg::ST_UPDATED;
                            end
                        end
                        chte_pkg::CMD_DELETE:
                        begin
                            vo_next = 32'(v_rdata);
                            st_next = chte_pkg::ST_FOUND;
                            if (prev_reg == NULL_LINK)
                            begin
                                hd_we = 1'b1;
                                hd_wdata = l_rdata;
                            end
                            else
                            begin
                                l_we = 1'b1;
                                l_waddr = prev_reg[EW-1:0];
                                l_wdata = l_rdata;
                            end
                            if (free_top_reg < FULL)
                            begin
                                f_we = 1'b1;
                                free_top_next = free_top_reg + LW'(1);
                            end
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - LW'(1);
                            end
                        end
                        chte_pkg::CMD_LOOKUP:
                        begin
                            vo_next = 32'(v_rdata);
                            st_next = chte_pkg::ST_FOUND;
                        end
                        default:
                        begin
                            vo_next = '0;
                            st_next = chte_pkg::ST_MISSING;
                        end
                    endcase
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next = l_rdata;
                    steps_next = steps_reg + LW'(1);
                    state_next = S_READ;
                end
            end
            S_POP:
            begin
                // prev_reg holds the chain tail; cur_next keeps the read idle
                slot_next = LW'(free_slot);
                free_top_next = free_top_reg - LW'(1);
                count_next = count_reg + LW'(1);
                if (free_top_next < free_low_reg)
                begin
                    free_low_next = free_top_next;
                end
                state_next = S_LINK;
            end
            S_LINK:
            begin
                e_we = 1'b1;
                k_we = 1'b1;
                e_waddr = slot_reg[EW-1:0];
                l_we = 1'b1;
                l_waddr = slot_reg[EW-1:0];
                l_wdata = NULL_LINK;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                if (prev_reg == NULL_LINK)
                begin
                    hd_we = 1'b1;
                    hd_wdata = slot_reg;
                end
                else
                begin
                    l_we = 1'b1;
                    l_waddr = prev_reg[EW-1:0];
                    l_wdata = slot_reg;
                end
                st_next = chte_pkg::ST_INSERTED;
                vo_next = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    out_st_next = st_reg;
                    out_vo_next = vo_reg;
                    out_held_next = 11'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            free_top_reg <= FULL;
            count_reg <= '0;
            ov_reg <= 1'b0;
            free_low_reg <= FULL;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            free_top_reg <= free_top_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
            free_low_reg <= free_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        val_reg <= val_next;
        bkt_reg <= bkt_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        slot_reg <= slot_next;
        steps_reg <= steps_next;
        st_reg <= st_next;
        vo_reg <= vo_next;
        out_st_reg <= out_st_next;
        out_vo_reg <= out_vo_next;
        out_held_reg <= out_held_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL) else $error("entry count out of range");
    a_pool_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(free_top_reg)) == 32'(ENTRIES))
        else $error("free stack and count disagree");
    a_out_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'd5) else $error("bad status code");
endmodule

/* tb/sv/chained_hash_table_engine_tb.sv */
// chained_hash_table_engine_tb: self-checking bench for the chained hash table engine.
// Drives insert/delete/lookup/none requests with random gaps, compares every result
// against a behavioral table kept here. Depends on chte_pkg and the engine RTL.
`timescale 1ns / 1ps

module chained_hash_table_engine_tb;

    localparam int BUCKETS = 256;
    localparam int ENTRIES = 1024;
    localparam int NIL     = ENTRIES;

    typedef struct packed {
        chte_pkg::cmd_t cmd;
        logic [31:0]    key;
        logic [31:0]    value;
    } request_t;

    typedef struct packed {
        chte_pkg::status_t status;
        logic [31:0]       value_out;
        logic [10:0]       entries_held;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [10:0] entries_held;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       error_count;
    int       in_gap;
    int       out_gap;

    int          tbl_head[BUCKETS];
    logic [31:0] tbl_key[ENTRIES];
    logic [31:0] tbl_value[ENTRIES];
    int          tbl_link[ENTRIES];
    int          tbl_free[ENTRIES];
    int          tbl_free_top;
    int          tbl_count;
    logic [31:0] key_pool[$];

    chained_hash_table_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_out    (value_out),
        .entries_held (entries_held)
    );

    always #5 clk = ~clk;

    function automatic int hash_bucket(logic [31:0] k);
        logic [31:0] h;
        h = k;
        h = ((h >> 16) ^ h) * chte_pkg::HASH_MUL;
        h = ((h >> 16) ^ h) * chte_pkg::HASH_MUL;
        h = (h >> 16) ^ h;
        return int'(h % BUCKETS);
    endfunction

    function automatic result_t apply_request(request_t r);
        result_t res;
        int      b;
        int      cur;
        int      prev;
        int      hit;
        int      slot;
        b    = hash_bucket(r.key);
        cur  = tbl_head[b];
        prev = NIL;
        hit  = NIL;
        res  = '{chte_pkg::ST_MISSING, 32'd0, 11'd0};
        while (cur != NIL && hit == NIL)
        begin
            if (tbl_key[cur] == r.key)
                hit = cur;
            else
            begin
                prev = cur;
                cur  = tbl_link[cur];
            end
        end
        case (r.cmd)
            chte_pkg::CMD_INSERT:
            begin
                if (hit != NIL)
                begin
                    if (tbl_value[hit] == r.value)
                        res.status = chte_pkg::ST_SAME;
                    else
                    begin
                        tbl_value[hit] = r.value;
                        res.status = chte_pkg::ST_UPDATED;
                    end
                end
                else if (tbl_free_top == 0)
                    res.status = chte_pkg::ST_NO_SPACE;
                else
                begin
                    tbl_free_top--;
                    slot = tbl_free[tbl_free_top];
                    tbl_key[slot]   = r.key;
                    tbl_value[slot] = r.value;
                    tbl_link[slot]  = NIL;
                    if (prev == NIL)
                        tbl_head[b] = slot;
                    else
                        tbl_link[prev] = slot;
                    tbl_count++;
                    res.status = chte_pkg::ST_INSERTED;
                end
            end
            chte_pkg::CMD_DELETE:
            begin
                if (hit != NIL)
                begin
                    res.value_out = tbl_value[hit];
                    if (prev == NIL)
                        tbl_head[b] = tbl_link[hit];
                    else
                        tbl_link[prev] = tbl_link[hit];
                    tbl_free[tbl_free_top] = hit;
                    tbl_free_top++;
                    tbl_count--;
                    res.status = chte_pkg::ST_FOUND;
                end
            end
            chte_pkg::CMD_LOOKUP:
            begin
                if (hit != NIL)
                begin
                    res.value_out = tbl_value[hit];
                    res.status = chte_pkg::ST_FOUND;
                end
            end
            default: ;
        endcase
        res.entries_held = 11'(tbl_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    task automatic push_request(chte_pkg::cmd_t c, logic [31:0] k, logic [31:0] v);
        pending_requests.push_back('{c, k, v});
        if (c == chte_pkg::CMD_INSERT)
            key_pool.push_back(k);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= 2'd0;
            key      <= 32'd0;
            value    <= 32'd0;
            in_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_results.push_back(
                    apply_request('{chte_pkg::cmd_t'(cmd), key, value}));
            if (in_gap > 0 || pending_requests.size() == 0)
            begin
                in_valid <= 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
            end
            else
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid <= 1'b1;
                cmd      <= r.cmd;
                key      <= r.key;
                value    <= r.value;
                in_gap   <= pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_t want;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (value_out !== want.value_out)
                        report_mismatch("value_out", value_out, want.value_out);
                    if (entries_held !== want.entries_held)
                        report_mismatch("entries_held", 32'(entries_held),
                                        32'(want.entries_held));
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap   <= (out_valid && out_ready) ? pick_gap() : 0;
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        error_count   = 0;
        for (int i = 0; i < BUCKETS; i++)
            tbl_head[i] = NIL;
        for (int i = 0; i < ENTRIES; i++)
            tbl_free[i] = i;
        tbl_free_top = ENTRIES;
        tbl_count    = 0;

        push_request(chte_pkg::CMD_LOOKUP, 32'h0, 32'h0);
        push_request(chte_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
        push_request(chte_pkg::CMD_INSERT, 32'h0, 32'h0);
        push_request(chte_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(chte_pkg::CMD_INSERT, 32'h0, 32'h0);
        push_request(chte_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
        push_request(chte_pkg::CMD_LOOKUP, 32'h0, 32'h1234_5678);
        push_request(chte_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        push_request(chte_pkg::CMD_NONE, 32'h0, 32'hFFFF_FFFF);
        push_request(chte_pkg::CMD_NONE, 32'h1, 32'h0);
        push_request(chte_pkg::CMD_DELETE, 32'h0, 32'h0);
        push_request(chte_pkg::CMD_LOOKUP, 32'h0, 32'h0);
        push_request(chte_pkg::CMD_DELETE, 32'h0, 32'h0);
        push_request(chte_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
        for (int i = 0; i < 8; i++)
            push_request(chte_pkg::CMD_INSERT, 32'(i * BUCKETS), $urandom());
        for (int i = 7; i >= 0; i -= 3)
            push_request(chte_pkg::CMD_DELETE, 32'(i * BUCKETS), 32'h0);

        // fill the pool past capacity, then run a random mix of deletes, lookups and inserts on it
        for (int i = 0; i < ENTRIES + 20; i++)
            push_request(chte_pkg::CMD_INSERT, $urandom(), $urandom());
        for (int i = 0; i < 40; i++)
        begin
            int roll;
            roll = $urandom_range(0, 99);
            if (roll < 40)
                push_request(chte_pkg::CMD_DELETE, pick_key(), $urandom());
            else if (roll < 70)
                push_request(chte_pkg::CMD_LOOKUP, pick_key(), $urandom());
            else if (roll < 97)
                push_request(chte_pkg::CMD_INSERT, pick_key(),
                             ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom());
            else
                push_request(chte_pkg::CMD_NONE, pick_key(), $urandom());
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("** chained_hash_table_engine: PASSED **");
        else
            $display("** chained_hash_table_engine: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** chained_hash_table_engine: FAILED **");
        $finish;
    end

endmodule
